>>> hw/rtl/joybus_eeprom_responder_assert.svh
// Assertion macros used by the checker of the EEPROM responder.
`ifndef JOYBUS_EEPROM_RESPONDER_ASSERT_SVH
`define JOYBUS_EEPROM_RESPONDER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define JBEE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define JBEE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/jbee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jbee_pkg;

    // Command bytes of the frame.
    localparam logic [7:0] CMD_STATUS = 8'h00;
    localparam logic [7:0] CMD_RESET  = 8'hFF;
    localparam logic [7:0] CMD_READ   = 8'h04;
    localparam logic [7:0] CMD_WRITE  = 8'h05;

    // Middle byte of the status answer.
    localparam logic [7:0] STATUS_4K  = 8'h80;
    localparam logic [7:0] STATUS_16K = 8'hC0;

    // Sizes of the two EEPROM variants.
    localparam int unsigned BYTES_4K   = 512;
    localparam int unsigned BYTES_16K  = 2048;
    localparam int unsigned BLOCKS_4K  = BYTES_4K / 8;
    localparam int unsigned BLOCKS_16K = BYTES_16K / 8;

    // Frame lengths that matter to the decode.
    localparam logic [3:0] HDR_BYTES  = 4'd2;
    localparam logic [3:0] STATUS_LEN = 4'd3;
    localparam logic [3:0] WRITE_ACK_LEN = 4'd1;

    // Configuration register map.
    localparam int unsigned    PADDR_W      = 1;
    localparam logic [PADDR_W-1:0] REG_SIZE_SEL = 1'b0;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  block_number;
        logic [3:0]  send_length;
        logic [3:0]  recv_length;
        logic [63:0] write_bytes;
    } t_in_item;

    typedef struct packed {
        logic        response_valid;
        logic [63:0] response_bytes;
        logic [3:0]  response_count;
    } t_out_item;

    // Write request from the frame evaluation to the block store.
    typedef struct packed {
        logic        en;
        logic [63:0] word;
    } t_wr_req;

    // Byte lane mask with the lowest n lanes set.
    function automatic logic [63:0] lane_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jbee_frame_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes one frame against the current contents of its block and forms
// the answer together with the merged block word for a write.
module jbee_frame_eval #(
    parameter int unsigned MAX_DATA_BYTES = 8
) (
    input  wire jbee_pkg::t_in_item  i_item,
    input  wire                      i_is_16k,
    input  wire logic [63:0]         i_word,
    output jbee_pkg::t_out_item      o_res,
    output jbee_pkg::t_wr_req        o_wr
);

    localparam logic [3:0] CAP = 4'(MAX_DATA_BYTES);

    logic        is_status;
    logic        is_read;
    logic        is_write;
    logic [3:0]  rd_n;
    logic [3:0]  wr_raw;
    logic [3:0]  wr_n;
    logic [63:0] rd_mask;
    logic [63:0] wr_mask;

    always_comb begin
        is_status = (i_item.cmd == jbee_pkg::CMD_STATUS) ||
                    (i_item.cmd == jbee_pkg::CMD_RESET);
        is_read   = (i_item.cmd == jbee_pkg::CMD_READ) &&
                    (i_item.send_length >= jbee_pkg::HDR_BYTES);
        is_write  = (i_item.cmd == jbee_pkg::CMD_WRITE) &&
                    (i_item.send_length >= jbee_pkg::HDR_BYTES) &&
                    (i_item.recv_length != 4'd0);

        rd_n    = (i_item.recv_length > CAP) ? CAP : i_item.recv_length;
        wr_raw  = i_item.send_length - jbee_pkg::HDR_BYTES;
        wr_n    = (wr_raw > CAP) ? CAP : wr_raw;
        rd_mask = jbee_pkg::lane_mask(rd_n);
        wr_mask = jbee_pkg::lane_mask(wr_n);

        o_res = '0;
        if (is_status) begin
            o_res.response_valid = 1'b1;
            o_res.response_bytes = {48'd0,
                (i_is_16k ? jbee_pkg::STATUS_16K : jbee_pkg::STATUS_4K), 8'd0};
            o_res.response_count = jbee_pkg::STATUS_LEN;
        end else if (is_read) begin
            o_res.response_valid = 1'b1;
            o_res.response_bytes = i_word & rd_mask;
            o_res.response_count = rd_n;
        end else if (is_write) begin
            o_res.response_valid = 1'b1;
            o_res.response_count = jbee_pkg::WRITE_ACK_LEN;
        end

        o_wr.en   = is_write;
        o_wr.word = (i_word & ~wr_mask) | (i_item.write_bytes & wr_mask);
    end

endmodule

`default_nettype wire

>>> hw/rtl/joybus_eeprom_responder.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartridge EEPROM responder: each input item is one command frame and
// yields exactly one result item. A status frame answers 00 80 00 or
// 00 C0 00, a read returns up to eight bytes of the addressed 8-byte block,
// and a write merges its data into the block and answers one zero byte.
// The block store is a memory with one read and one write port. It is read
// on the cycle an item is taken, and the item then sits in the evaluation
// register, where the answer is formed and any write lands. The result is
// offered from the result register, which is loaded from the evaluation
// register as the item moves on. An item waits in the evaluation register
// for as long as the result ahead of it is held off, and the input stalls
// while it waits; with no hold-off one item can be taken every cycle.
// Back-to-back frames that hit the same block are served by forwarding the
// freshly merged word, so no stall is needed for them. The store reads as
// all zeros after reset through one valid bit per block; there is no
// clearing pass and items are accepted as soon as reset is released.
// The size selection (register 0, bit 0) sets the status answer and whether
// block numbers wrap at 64 or at 256 blocks, capped at BLOCK_COUNT; it
// should only be changed while no item is in flight.
module joybus_eeprom_responder #(
    parameter int unsigned BLOCK_COUNT    = 256,
    parameter int unsigned MAX_DATA_BYTES = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,

    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire jbee_pkg::t_in_item         i_in_item,

    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output jbee_pkg::t_out_item             o_out_item,

    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [jbee_pkg::PADDR_W-1:0]     paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int unsigned IDX_W = $clog2(BLOCK_COUNT);
    // Active block counts, never beyond what the store holds.
    localparam int unsigned ACT_4K  = (jbee_pkg::BLOCKS_4K < BLOCK_COUNT) ?
                                      jbee_pkg::BLOCKS_4K : BLOCK_COUNT;
    localparam int unsigned ACT_16K = (jbee_pkg::BLOCKS_16K < BLOCK_COUNT) ?
                                      jbee_pkg::BLOCKS_16K : BLOCK_COUNT;

    // Block number wrapped to the active size. With at least 64 blocks an
    // 8-bit block number needs no more than three subtractions.
    function automatic logic [IDX_W-1:0] wrap_block(input logic [7:0] blk,
                                                    input logic       big);
        logic [8:0] v;
        logic [8:0] n;
        v = {1'b0, blk};
        n = big ? 9'(ACT_16K) : 9'(ACT_4K);
        for (int i = 0; i < 3; i++) begin
            if (v >= n) begin
                v = v - n;
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // Configuration.
    logic r_is_16k;
    logic cfg_wr;

    // Evaluation stage.
    logic                r_a_vld;
    jbee_pkg::t_in_item  r_a_item;
    logic [IDX_W-1:0]    r_a_idx;
    logic [IDX_W-1:0]    n_idx;

    // Block store and its read port.
    logic [63:0]         r_mem [BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] r_blk_vld;
    logic [63:0]         r_rd_data;
    logic                r_rd_vld;
    logic                r_fwd;
    logic [63:0]         r_fwd_word;
    logic [63:0]         cur_word;

    // Result register.
    logic                r_out_vld;
    jbee_pkg::t_out_item r_out_item;

    jbee_pkg::t_out_item eval_res;
    jbee_pkg::t_wr_req   eval_wr;

    logic in_acc;
    logic a_adv;
    logic mem_wr;

    // ---------------------------------------------------------------
    // Configuration port: one register, always ready.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == jbee_pkg::REG_SIZE_SEL);

    always_comb begin
        prdata = '0;
        if (paddr == jbee_pkg::REG_SIZE_SEL) begin
            prdata = {31'd0, r_is_16k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_16k <= 1'b0;
        end else if (cfg_wr) begin
            r_is_16k <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------
    // Handshake. The evaluation stage moves on whenever the result
    // register is empty or being emptied; a new item may enter in the
    // same cycle.
    // ---------------------------------------------------------------
    assign a_adv      = r_a_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_a_vld && !a_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign mem_wr     = a_adv && eval_wr.en;
    assign n_idx      = wrap_block(i_in_item.block_number, r_is_16k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_item <= i_in_item;
            r_a_idx  <= n_idx;
        end
    end

    // ---------------------------------------------------------------
    // Block store. The read is taken as the item is accepted. When the
    // item ahead writes the same block at that very edge, the merged
    // word is captured instead of the stale memory data.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_a_idx] <= eval_wr.word;
        end
        if (in_acc) begin
            r_rd_data <= r_mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= '0;
        end else if (mem_wr) begin
            r_blk_vld[r_a_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else if (in_acc) begin
            r_rd_vld <= r_blk_vld[n_idx];
            r_fwd    <= mem_wr && (n_idx == r_a_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_word <= eval_wr.word;
        end
    end

    // A block never written reads as zero.
    assign cur_word = r_fwd    ? r_fwd_word :
                      r_rd_vld ? r_rd_data  : 64'd0;

    jbee_frame_eval #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_eval (
        .i_item   (r_a_item),
        .i_is_16k (r_is_16k),
        .i_word   (cur_word),
        .o_res    (eval_res),
        .o_wr     (eval_wr)
    );

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (a_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out_item <= eval_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

>>> hw/rtl/jbee_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "joybus_eeprom_responder_assert.svh"

// Watches the ports of the EEPROM responder.
module jbee_port_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       o_in_stall,
    input  wire                       o_out_valid,
    input  wire                       i_out_stall,
    input  wire jbee_pkg::t_out_item  o_out_item,
    input  wire                       pready
);

    `JBEE_ASSERT_ALWAYS(a_pready_high, pready, "configuration port not ready")
    `JBEE_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled result item changed")
    `JBEE_ASSERT(a_out_latency, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2), "result item without an accepted item two cycles before")
    `JBEE_ASSERT(a_reject_clean, o_out_valid && !o_out_item.response_valid |-> o_out_item.response_bytes == 64'd0 && o_out_item.response_count == 4'd0, "unanswered frame carries data")
    `JBEE_ASSERT(a_count_range, o_out_valid |-> o_out_item.response_count <= 4'd8, "response count above eight")

endmodule

bind joybus_eeprom_responder jbee_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .pready      (pready)
);

`default_nettype wire
